// File: rtl/core/goci_pkg.sv
// Shared constants and types for the gyro offset calibration integrator.
package goci_pkg;

   localparam int AXES        = 3;
   localparam int RATE_W      = 16;
   localparam int FRAC_W      = 16;
   localparam int CAL_SAMPLES = 1000;
   localparam int CAL_CNT_W   = 10;
   localparam int SUM_W       = 27;
   localparam int MAG_W       = SUM_W - 1;
   localparam int OFS_W       = 33;
   localparam int QUO_W       = OFS_W - FRAC_W;
   localparam int RECIP_K     = MAG_W + CAL_CNT_W;
   localparam int RECIP_W     = RECIP_K + 1 - $clog2(CAL_SAMPLES);
   localparam int CORR_W      = 34;
   localparam int TRAP_W      = 35;
   localparam int ACC_W       = 64;
   localparam int HALF_W      = ACC_W / 2;
   localparam int SCALE_W     = 32;
   localparam int PROD_W      = HALF_W + SCALE_W;
   localparam int ANGLE_W     = 32;

   // The reciprocal is rounded up; the shift is wide enough that the quotient
   // and the fraction both come out exact for every possible sum.
   localparam longint RECIP_FULL = ((longint'(1) << RECIP_K) + longint'(CAL_SAMPLES) - 1)
                                   / longint'(CAL_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   localparam logic [SCALE_W-1:0] ANGLE_SCALE_RESET = 32'd11438;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_RECAL  = 1'b1;

   typedef logic signed [RATE_W-1:0]  rate_type;
   typedef logic signed [OFS_W-1:0]   offset_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      logic take;
      logic acc_load;
      logic prod_load;
      logic out_load;
   } pipe_ctl_type;

endpackage

// File: rtl/core/gyro_offset_cal_integrator_unit.sv
// Top level of the gyro offset calibration and trapezoidal angle integrator.
//
// Input words arrive on the req_ stream: tuser carries the command bit and
// tdata the three signed rate samples. A word with the command bit set
// restarts offset calibration and gives no result. After reset or a restart,
// the next 1000 sample words are summed per axis and give no result. The last
// of them starts a divider that forms the offsets by reciprocal multiplication
// in three steps; req_tready stays low while it runs.
// Every later sample word yields one result word on the rsp_ stream holding
// the three angles. A result passes the trapezoid, accumulator, product and
// angle registers after its input word is accepted; one input word is taken
// per cycle while the divider is idle. Stages hand data forward independently,
// so new words are taken while a result waits, until the pipeline is full. When
// the receiver stalls, results hold and input stalls once all stages are full.
// Reset returns to calibration with zero sums, offsets, rates and angle accumulators
// and restores angle_scale to its default. The csr_ port writes angle_scale.
module gyro_offset_cal_integrator_unit
   import goci_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // rate_x, rate_y, rate_z
   input  logic                 req_tuser,   // command
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,   // angle_x, angle_y, angle_z
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [SCALE_W-1:0]   csr_wdata
);

   logic [SCALE_W-1:0] scale_ff;
   logic               s1_v_ff;
   logic               s2_v_ff;
   logic               s3_v_ff;
   logic               out_v_ff;
   logic               en1;
   logic               en2;
   logic               en3;
   logic               en4;
   logic               req_fire;
   logic               calibrating;
   logic               busy;
   rate_type           rate [AXES];
   offset_type         offset [AXES];
   acc_type            acc [AXES];
   angle_type          angle [AXES];
   pipe_ctl_type       ctl;

   assign rate[0] = req_tdata[RATE_W-1:0];
   assign rate[1] = req_tdata[2*RATE_W-1:RATE_W];
   assign rate[2] = req_tdata[3*RATE_W-1:2*RATE_W];

   assign en4 = !out_v_ff || rsp_tready;
   assign en3 = !s3_v_ff || en4;
   assign en2 = !s2_v_ff || en3;
   assign en1 = !s1_v_ff || en2;

   assign req_tready = en1 && !busy;
   assign req_fire   = req_tvalid && req_tready;

   assign ctl.take      = req_fire && (req_tuser == CMD_SAMPLE) && !calibrating;
   assign ctl.acc_load  = s1_v_ff && en2;
   assign ctl.prod_load = s2_v_ff && en3;
   assign ctl.out_load  = s3_v_ff && en4;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ANGLE_SCALE_RESET;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            scale_ff <= csr_wdata;
         end
         if (en1) begin
            s1_v_ff <= ctl.take;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (en3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (en4) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   goci_calib u_calib (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .command     (req_tuser),
      .rate        (rate),
      .calibrating (calibrating),
      .busy        (busy),
      .offset      (offset)
   );

   goci_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .rate   (rate),
      .offset (offset),
      .acc    (acc)
   );

   goci_scale u_scale (
      .clock (clock),
      .ctl   (ctl),
      .scale (scale_ff),
      .acc   (acc),
      .angle (angle)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {angle[2], angle[1], angle[0]};

endmodule

// File: rtl/core/goci_calib.sv
// Offset calibration: per-axis sample sums and a reciprocal divide by the sample count.
module goci_calib
   import goci_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       command,
   input  rate_type   rate [AXES],
   output logic       calibrating,
   output logic       busy,
   output offset_type offset [AXES]
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_QUOT,
      DIV_REM,
      DIV_APPLY
   } div_state_type;

   div_state_type                div_state_ff;
   logic                         calibrating_ff;
   logic [CAL_CNT_W-1:0]         count_ff;
   logic signed [SUM_W-1:0]      sum_ff [AXES];
   logic signed [SUM_W-1:0]      sum_in [AXES];
   logic [SUM_W-1:0]             mag_in [AXES];
   logic [MAG_W-1:0]             mag_ff [AXES];
   logic                         neg_ff [AXES];
   logic [MAG_W+RECIP_W-1:0]     quot_prod [AXES];
   logic [QUO_W-1:0]             quot_in [AXES];
   logic [QUO_W-1:0]             quot_ff [AXES];
   logic [MAG_W-1:0]             back_prod [AXES];
   logic [CAL_CNT_W-1:0]         rem_in [AXES];
   logic [CAL_CNT_W-1:0]         rem_ff [AXES];
   logic [CAL_CNT_W+RECIP_W-1:0] frac_prod [AXES];
   logic [OFS_W-1:0]             qmag [AXES];
   offset_type                   offset_in [AXES];
   offset_type                   offset_ff [AXES];
   logic [CAL_CNT_W:0]           count_inc;
   logic                         last_sample;
   logic                         cal_done;

   assign count_inc   = {1'b0, count_ff} + 1'b1;
   assign last_sample = (count_inc == (CAL_CNT_W + 1)'(CAL_SAMPLES));
   assign cal_done    = fire && (command == CMD_SAMPLE) && calibrating_ff && last_sample;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sum_in[i]    = sum_ff[i] + SUM_W'(rate[i]);
         mag_in[i]    = sum_in[i][SUM_W-1] ? SUM_W'(-sum_in[i]) : SUM_W'(sum_in[i]);
         quot_prod[i] = (MAG_W + RECIP_W)'(mag_ff[i]) * (MAG_W + RECIP_W)'(RECIP);
         quot_in[i]   = quot_prod[i][RECIP_K +: QUO_W];
         back_prod[i] = MAG_W'(quot_ff[i]) * MAG_W'(CAL_SAMPLES);
         rem_in[i]    = CAL_CNT_W'(mag_ff[i] - back_prod[i]);
         frac_prod[i] = (CAL_CNT_W + RECIP_W)'(rem_ff[i]) * (CAL_CNT_W + RECIP_W)'(RECIP);
         qmag[i]      = {quot_ff[i], frac_prod[i][RECIP_K-FRAC_W +: FRAC_W]};
         offset_in[i] = neg_ff[i] ? $signed(qmag[i]) : -$signed(qmag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_state_ff   <= DIV_IDLE;
         calibrating_ff <= 1'b1;
         count_ff       <= '0;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i]    <= '0;
            offset_ff[i] <= '0;
         end
      end else begin
         if (fire) begin
            if (command == CMD_RECAL) begin
               calibrating_ff <= 1'b1;
               count_ff       <= '0;
               for (int i = 0; i < AXES; i++) begin
                  sum_ff[i] <= '0;
               end
            end else if (calibrating_ff) begin
               for (int i = 0; i < AXES; i++) begin
                  sum_ff[i] <= sum_in[i];
               end
               if (last_sample) begin
                  calibrating_ff <= 1'b0;
                  count_ff       <= '0;
               end else begin
                  count_ff <= count_inc[CAL_CNT_W-1:0];
               end
            end
         end
         case (div_state_ff)
            DIV_IDLE: begin
               if (cal_done) begin
                  div_state_ff <= DIV_QUOT;
               end
            end
            DIV_QUOT: begin
               div_state_ff <= DIV_REM;
            end
            DIV_REM: begin
               div_state_ff <= DIV_APPLY;
            end
            DIV_APPLY: begin
               div_state_ff <= DIV_IDLE;
               for (int i = 0; i < AXES; i++) begin
                  offset_ff[i] <= offset_in[i];
               end
            end
            default: begin
               div_state_ff <= DIV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < AXES; i++) begin
         if (cal_done) begin
            mag_ff[i] <= mag_in[i][MAG_W-1:0];
            neg_ff[i] <= sum_in[i][SUM_W-1];
         end
         if (div_state_ff == DIV_QUOT) begin
            quot_ff[i] <= quot_in[i];
         end
         if (div_state_ff == DIV_REM) begin
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   assign calibrating = calibrating_ff;
   assign busy        = (div_state_ff != DIV_IDLE);
   assign offset      = offset_ff;

endmodule

// File: rtl/core/goci_accum.sv
// Rate correction, trapezoid sum and saturating angle accumulators.
module goci_accum
   import goci_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pipe_ctl_type ctl,
   input  rate_type     rate [AXES],
   input  offset_type   offset [AXES],
   output acc_type      acc [AXES]
);

   logic signed [CORR_W-1:0] prev_ff [AXES];
   logic signed [CORR_W-1:0] corr_in [AXES];
   logic signed [TRAP_W-1:0] trap_ff [AXES];
   logic signed [TRAP_W-1:0] trap_in [AXES];
   acc_type                  acc_ff [AXES];
   acc_type                  acc_in [AXES];
   logic signed [ACC_W:0]    wide_sum [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         corr_in[i]  = CORR_W'($signed({rate[i], FRAC_W'(0)})) + CORR_W'(offset[i]);
         trap_in[i]  = TRAP_W'(prev_ff[i]) + TRAP_W'(corr_in[i]);
         wide_sum[i] = (ACC_W + 1)'(acc_ff[i]) + (ACC_W + 1)'(trap_ff[i]);
         if (wide_sum[i][ACC_W] != wide_sum[i][ACC_W-1]) begin
            acc_in[i] = wide_sum[i][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                           : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_in[i] = wide_sum[i][ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            prev_ff[i] <= '0;
            acc_ff[i]  <= '0;
         end
      end else begin
         for (int i = 0; i < AXES; i++) begin
            if (ctl.take) begin
               prev_ff[i] <= corr_in[i];
            end
            if (ctl.acc_load) begin
               acc_ff[i] <= acc_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         for (int i = 0; i < AXES; i++) begin
            trap_ff[i] <= trap_in[i];
         end
      end
   end

   assign acc = acc_ff;

endmodule

// File: rtl/core/goci_scale.sv
// Angle scaling: split 64 by 32 multiply, floor shift by 32 and saturation.
module goci_scale
   import goci_pkg::*;
(
   input  logic               clock,
   input  pipe_ctl_type       ctl,
   input  logic [SCALE_W-1:0] scale,
   input  acc_type            acc [AXES],
   output angle_type          angle [AXES]
);

   logic signed [PROD_W:0]   hi_prod [AXES];
   logic [PROD_W-1:0]        lo_prod [AXES];
   logic signed [PROD_W-1:0] p_hi_ff [AXES];
   logic [PROD_W-1:0]        p_lo_ff [AXES];
   logic signed [PROD_W:0]   q_in [AXES];
   angle_type                angle_ff [AXES];
   angle_type                angle_in [AXES];
   logic signed [SCALE_W:0]  scale_s;

   assign scale_s = $signed({1'b0, scale});

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         hi_prod[i] = $signed(acc[i][ACC_W-1:HALF_W]) * scale_s;
         lo_prod[i] = acc[i][HALF_W-1:0] * scale;
         q_in[i]    = (PROD_W + 1)'(p_hi_ff[i])
                    + $signed({1'b0, PROD_W'(p_lo_ff[i][PROD_W-1:HALF_W])});
         if (q_in[i][PROD_W:ANGLE_W-1] == '0 || q_in[i][PROD_W:ANGLE_W-1] == '1) begin
            angle_in[i] = q_in[i][ANGLE_W-1:0];
         end else begin
            angle_in[i] = q_in[i][PROD_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                          : {1'b0, {(ANGLE_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < AXES; i++) begin
         if (ctl.prod_load) begin
            p_hi_ff[i] <= hi_prod[i][PROD_W-1:0];
            p_lo_ff[i] <= lo_prod[i];
         end
         if (ctl.out_load) begin
            angle_ff[i] <= angle_in[i];
         end
      end
   end

   assign angle = angle_ff;

endmodule
